[rtl/psle_pkg.sv]
package psle_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int IDX_W      = 4;
    localparam int CMD_W      = 4;

    typedef logic [DATA_WIDTH-1:0] word_t;
    typedef logic [ADDR_W-1:0]     addr_t;
    typedef logic [CNT_W-1:0]      cnt_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND  = 4'd0,
        CMD_DROP    = 4'd1,
        CMD_INSERT  = 4'd2,
        CMD_REMOVE  = 4'd3,
        CMD_FIND    = 4'd4,
        CMD_READ    = 4'd5,
        CMD_SORTED  = 4'd6,
        CMD_CLEAR   = 4'd7,
        CMD_REVERSE = 4'd8,
        CMD_STATUS  = 4'd9
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP_RD,
        ST_UP_WR,
        ST_DN_RD,
        ST_DN_WR,
        ST_RV_LO,
        ST_RV_HI,
        ST_RV_WLO,
        ST_RV_WHI,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic  we;
        addr_t waddr;
        word_t wdata;
        addr_t raddr;
    } ram_req_t;

    typedef struct packed {
        logic lt;
        logic hit;
    } cmp_res_t;

endpackage

[rtl/psle_ram.sv]
module psle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/psle_cmp.sv]
module psle_cmp (
    input  psle_pkg::word_t    lhs,
    input  psle_pkg::word_t    rhs,
    input  psle_pkg::word_t    key,
    output psle_pkg::cmp_res_t res
);
    import psle_pkg::*;

    // signed order and exact match
    always_comb
    begin
        res.lt  = $signed(lhs) < $signed(rhs);
        res.hit = lhs == key;
    end

endmodule

[rtl/psle_ctrl.sv]
module psle_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [3:0]              command,
    input  logic signed [31:0]      value,
    input  logic [4:0]              position,
    input  psle_pkg::cnt_t          limit,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    ok,
    output logic signed [31:0]      value_out,
    output logic [3:0]              index_out,
    output logic [4:0]              fill_level,
    output logic                    is_empty,
    output logic                    is_full,
    output logic [4:0]              free_slots,
    output logic                    in_order,
    output psle_pkg::ram_req_t      ram_req,
    input  psle_pkg::word_t         ram_rdata
);
    import psle_pkg::*;

    state_t   state_reg, state_next;
    cnt_t     fill_reg, fill_next;
    cmd_t     cmd_reg, cmd_next;
    word_t    word_reg, word_next;
    cnt_t     pos_reg, pos_next;
    cnt_t     ptr_reg, ptr_next;
    addr_t    hi_reg, hi_next;
    word_t    tmp_reg, tmp_next;
    logic     ok_reg, ok_next;
    cnt_t     issue_reg, issue_next;
    logic     rv_reg, rv_next;
    addr_t    ridx_reg, ridx_next;
    word_t    prev_reg, prev_next;
    logic     ord_reg, ord_next;
    addr_t    fidx_reg, fidx_next;
    word_t    rval_reg, rval_next;

    logic               out_valid_reg, out_valid_next;
    logic               ok_out_reg;
    logic signed [31:0] value_out_reg;
    logic [3:0]         index_out_reg;
    cnt_t               fill_out_reg;
    logic               empty_out_reg;
    logic               full_out_reg;
    cnt_t               free_out_reg;
    logic               order_out_reg;
    logic               load_out;

    word_t    cmp_rhs;
    cmp_res_t cmp_res;

    assign cmp_rhs = (state_reg == ST_SCAN) ? prev_reg : word_reg;

    psle_cmp u_cmp (
        .lhs (ram_rdata),
        .rhs (cmp_rhs),
        .key (word_reg),
        .res (cmp_res)
    );

    assign in_stall = state_reg != ST_IDLE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        word_reg  <= word_next;
        pos_reg   <= pos_next;
        ptr_reg   <= ptr_next;
        hi_reg    <= hi_next;
        tmp_reg   <= tmp_next;
        ok_reg    <= ok_next;
        issue_reg <= issue_next;
        rv_reg    <= rv_next;
        ridx_reg  <= ridx_next;
        prev_reg  <= prev_next;
        ord_reg   <= ord_next;
        fidx_reg  <= fidx_next;
        rval_reg  <= rval_next;
        if (load_out)
        begin
            ok_out_reg    <= ok_reg;
            value_out_reg <= 32'(rval_reg);
            index_out_reg <= IDX_W'(fidx_reg);
            fill_out_reg  <= fill_reg;
            empty_out_reg <= fill_reg == '0;
            full_out_reg  <= fill_reg >= limit;
            free_out_reg  <= (limit > fill_reg) ? cnt_t'(limit - fill_reg) : '0;
            order_out_reg <= ord_reg;
        end
    end

    always_comb
    begin
        logic full;
        cnt_t lower;

        state_next     = state_reg;
        fill_next      = fill_reg;
        cmd_next       = cmd_reg;
        word_next      = word_reg;
        pos_next       = pos_reg;
        ptr_next       = ptr_reg;
        hi_next        = hi_reg;
        tmp_next       = tmp_reg;
        ok_next        = ok_reg;
        issue_next     = issue_reg;
        rv_next        = 1'b0;
        ridx_next      = ridx_reg;
        prev_next      = prev_reg;
        ord_next       = ord_reg;
        fidx_next      = fidx_reg;
        rval_next      = rval_reg;
        out_valid_next = out_valid_reg && out_stall;
        load_out       = 1'b0;
        ram_req        = '0;
        full           = fill_reg >= limit;
        lower          = (cmd_reg == CMD_SORTED) ? '0 : pos_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = cmd_t'(command);
                    word_next  = DATA_WIDTH'(value);
                    pos_next   = cnt_t'(position);
                    ok_next    = 1'b0;
                    issue_next = '0;
                    ord_next   = 1'b1;
                    fidx_next  = '0;
                    rval_next  = '0;
                    state_next = ST_SCAN;
                    unique case (cmd_t'(command))
                        CMD_APPEND:
                        begin
                            if (!full)
                            begin
                                ram_req.we    = 1'b1;
                                ram_req.waddr = fill_reg[ADDR_W-1:0];
                                ram_req.wdata = DATA_WIDTH'(value);
                                fill_next     = fill_reg + 1'b1;
                                ok_next       = 1'b1;
                            end
                        end
                        CMD_DROP:
                        begin
                            if (fill_reg != '0)
                            begin
                                fill_next = fill_reg - 1'b1;
                                ok_next   = 1'b1;
                            end
                        end
                        CMD_INSERT:
                        begin
                            if (!full && cnt_t'(position) <= fill_reg)
                            begin
                                ok_next    = 1'b1;
                                ptr_next   = fill_reg;
                                state_next = ST_UP_RD;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (cnt_t'(position) < fill_reg)
                            begin
                                ok_next    = 1'b1;
                                ptr_next   = cnt_t'(position);
                                state_next = ST_DN_RD;
                            end
                        end
                        CMD_FIND:
                        begin
                            ok_next = 1'b0;
                        end
                        CMD_READ:
                        begin
                            ok_next = cnt_t'(position) < fill_reg;
                        end
                        CMD_SORTED:
                        begin
                            if (!full)
                            begin
                                ok_next    = 1'b1;
                                ptr_next   = fill_reg;
                                state_next = ST_UP_RD;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            fill_next = '0;
                            ok_next   = 1'b1;
                        end
                        CMD_REVERSE:
                        begin
                            ok_next = 1'b1;
                            if (fill_reg > cnt_t'(1))
                            begin
                                ptr_next   = '0;
                                hi_next    = addr_t'(fill_reg - 1'b1);
                                state_next = ST_RV_LO;
                            end
                        end
                        CMD_STATUS:
                        begin
                            ok_next = 1'b1;
                        end
                        default:
                        begin
                            ok_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_UP_RD:
            begin
                if (ptr_reg > lower)
                begin
                    ram_req.raddr = addr_t'(ptr_reg - 1'b1);
                    state_next    = ST_UP_WR;
                end
                else
                begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = ptr_reg[ADDR_W-1:0];
                    ram_req.wdata = word_reg;
                    fill_next     = fill_reg + 1'b1;
                    state_next    = ST_SCAN;
                end
            end
            ST_UP_WR:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = ptr_reg[ADDR_W-1:0];
                if (cmd_reg == CMD_INSERT || !cmp_res.lt)
                begin
                    ram_req.wdata = ram_rdata;
                    ptr_next      = ptr_reg - 1'b1;
                    state_next    = ST_UP_RD;
                end
                else
                begin
                    ram_req.wdata = word_reg;
                    fill_next     = fill_reg + 1'b1;
                    state_next    = ST_SCAN;
                end
            end
            ST_DN_RD:
            begin
                if (ptr_reg + 1'b1 < fill_reg)
                begin
                    ram_req.raddr = addr_t'(ptr_reg + 1'b1);
                    state_next    = ST_DN_WR;
                end
                else
                begin
                    fill_next  = fill_reg - 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_DN_WR:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = ptr_reg[ADDR_W-1:0];
                ram_req.wdata = ram_rdata;
                ptr_next      = ptr_reg + 1'b1;
                state_next    = ST_DN_RD;
            end
            ST_RV_LO:
            begin
                ram_req.raddr = ptr_reg[ADDR_W-1:0];
                state_next    = ST_RV_HI;
            end
            ST_RV_HI:
            begin
                ram_req.raddr = hi_reg;
                tmp_next      = ram_rdata;
                state_next    = ST_RV_WLO;
            end
            ST_RV_WLO:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = ptr_reg[ADDR_W-1:0];
                ram_req.wdata = ram_rdata;
                state_next    = ST_RV_WHI;
            end
            ST_RV_WHI:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = hi_reg;
                ram_req.wdata = tmp_reg;
                ptr_next      = ptr_reg + 1'b1;
                hi_next       = hi_reg - 1'b1;
                state_next    = (ptr_next < cnt_t'(hi_next)) ? ST_RV_LO : ST_SCAN;
            end
            ST_SCAN:
            begin
                // one read issued per cycle, its data checked in the following cycle
                if (issue_reg < fill_reg)
                begin
                    ram_req.raddr = issue_reg[ADDR_W-1:0];
                    issue_next    = issue_reg + 1'b1;
                    rv_next       = 1'b1;
                    ridx_next     = issue_reg[ADDR_W-1:0];
                end
                if (rv_reg)
                begin
                    prev_next = ram_rdata;
                    if (ridx_reg != '0 && cmp_res.lt)
                    begin
                        ord_next = 1'b0;
                    end
                    if (cmd_reg == CMD_FIND && !ok_reg && cmp_res.hit)
                    begin
                        ok_next   = 1'b1;
                        fidx_next = ridx_reg;
                    end
                    if (cmd_reg == CMD_READ && cnt_t'(ridx_reg) == pos_reg)
                    begin
                        rval_next = ram_rdata;
                    end
                end
                if (issue_reg >= fill_reg && !rv_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign ok         = ok_out_reg;
    assign value_out  = value_out_reg;
    assign index_out  = index_out_reg;
    assign fill_level = fill_out_reg;
    assign is_empty   = empty_out_reg;
    assign is_full    = full_out_reg;
    assign free_slots = free_out_reg;
    assign in_order   = order_out_reg;

endmodule

[rtl/positional_sorted_list_engine_core.sv]
// Fixed-capacity list of 16 signed 32-bit entries driven by one command word at a time:
// append, drop last, insert at, remove at, find, read, sorted insert, clear, reverse and
// status, each answered with exactly one result word carrying the ok flag, the value or
// index asked for and the list status after the command. All entries sit in a single
// dual-address RAM (one write, one registered read per cycle) and one signed comparator
// serves sorted insert, order check and find. A command is taken in the idle state, then
// insert at, remove at and sorted insert move entries one at a time through a read state
// and a write state each, reverse swaps pairs by reading the low and the high entry and
// writing them back crossed, and every command then ends with a scan over the filled
// slots, which yields the in-order flag, the find match and the read value, and a finish
// state that loads the result. The command side stalls for the whole command; a finished
// result waits in the output register while the next command is taken. The capacity
// limit register resets to 16 (0 acts as 1, above 16 acts as 16) and is written through
// the cfg channel, which is always ready.
module positional_sorted_list_engine_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [3:0]         command,
    input  logic signed [31:0] value,
    input  logic [4:0]         position,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               ok,
    output logic signed [31:0] value_out,
    output logic [3:0]         index_out,
    output logic [4:0]         fill_level,
    output logic               is_empty,
    output logic               is_full,
    output logic [4:0]         free_slots,
    output logic               in_order,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [4:0]         cfg_data
);
    import psle_pkg::*;

    logic [4:0] limit_reg, limit_next;
    cnt_t       eff_limit;
    ram_req_t   ram_req;
    word_t      ram_rdata;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        limit_next = limit_reg;
        if (cfg_valid && cfg_ready)
        begin
            limit_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= 5'd16;
        end
        else
        begin
            limit_reg <= limit_next;
        end
    end

    // saturate the limit to 1 .. capacity
    always_comb
    begin
        priority if (limit_reg == '0)
        begin
            eff_limit = cnt_t'(1);
        end
        else if (CNT_W'(limit_reg) > cnt_t'(CAPACITY))
        begin
            eff_limit = cnt_t'(CAPACITY);
        end
        else
        begin
            eff_limit = CNT_W'(limit_reg);
        end
    end

    psle_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    psle_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .value      (value),
        .position   (position),
        .limit      (eff_limit),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .ok         (ok),
        .value_out  (value_out),
        .index_out  (index_out),
        .fill_level (fill_level),
        .is_empty   (is_empty),
        .is_full    (is_full),
        .free_slots (free_slots),
        .in_order   (in_order),
        .ram_req    (ram_req),
        .ram_rdata  (ram_rdata)
    );

endmodule

[dv/tb_positional_sorted_list_engine_core.sv]
module tb_positional_sorted_list_engine_core;

    import psle_pkg::*;

    localparam logic [3:0] FIRST_UNUSED_CMD = 4'd10;
    localparam logic [3:0] LAST_UNUSED_CMD  = 4'd15;
    localparam int         PHASES           = 9;
    localparam int         PHASE_WORDS      = 170;

    typedef struct {
        logic               ok;
        logic signed [31:0] value_out;
        logic [3:0]         index_out;
        logic [4:0]         fill_level;
        logic               is_empty;
        logic               is_full;
        logic [4:0]         free_slots;
        logic               in_order;
    } list_outcome_t;

    class list_scoreboard;
        logic signed [31:0] slots [CAPACITY];
        int                 fill;
        logic [4:0]         limit_reg;
        list_outcome_t      pending_outcomes [$];
        int                 errors;
        int                 commands;
        int                 results;
        int                 limit_writes;
        int                 full_results;
        int                 unordered_results;

        function new();
            fill      = 0;
            limit_reg = 5'd16;
        endfunction

        function void write_limit(logic [4:0] lim);
            limit_reg = lim;
            limit_writes++;
        endfunction

        function int pending();
            return pending_outcomes.size();
        endfunction

        function void take_command(logic [3:0] cmd, logic signed [31:0] val,
                                   logic [4:0] pos);
            list_outcome_t      r;
            int                 lim;
            int                 p;
            int                 i;
            int                 lo;
            int                 hi;
            bit                 full;
            logic signed [31:0] t;
            r = '{default: 0};
            p = int'(pos);
            lim = (limit_reg == 0) ? 1 : (limit_reg > CAPACITY) ? CAPACITY : int'(limit_reg);
            full = fill >= lim;
            commands++;
            case (cmd_t'(cmd))
                CMD_APPEND:
                    if (!full)
                    begin
                        slots[fill] = val;
                        fill++;
                        r.ok = 1'b1;
                    end
                CMD_DROP:
                    if (fill > 0)
                    begin
                        fill--;
                        r.ok = 1'b1;
                    end
                CMD_INSERT:
                    if (!full && p <= fill)
                    begin
                        for (i = fill; i > p; i--)
                            slots[i] = slots[i-1];
                        slots[p] = val;
                        fill++;
                        r.ok = 1'b1;
                    end
                CMD_REMOVE:
                    if (p < fill)
                    begin
                        for (i = p; i + 1 < fill; i++)
                            slots[i] = slots[i+1];
                        fill--;
                        r.ok = 1'b1;
                    end
                CMD_FIND:
                    for (i = 0; i < fill && !r.ok; i++)
                        if (slots[i] == val)
                        begin
                            r.ok = 1'b1;
                            r.index_out = 4'(i);
                        end
                CMD_READ:
                    if (p < fill)
                    begin
                        r.ok = 1'b1;
                        r.value_out = slots[p];
                    end
                CMD_SORTED:
                    if (!full)
                    begin
                        i = fill;
                        while (i > 0 && slots[i-1] >= val)
                        begin
                            slots[i] = slots[i-1];
                            i--;
                        end
                        slots[i] = val;
                        fill++;
                        r.ok = 1'b1;
                    end
                CMD_CLEAR:
                begin
                    fill = 0;
                    r.ok = 1'b1;
                end
                CMD_REVERSE:
                begin
                    lo = 0;
                    hi = fill - 1;
                    while (lo < hi)
                    begin
                        t = slots[lo];
                        slots[lo] = slots[hi];
                        slots[hi] = t;
                        lo++;
                        hi--;
                    end
                    r.ok = 1'b1;
                end
                CMD_STATUS:
                    r.ok = 1'b1;
                default:
                    ;
            endcase
            r.fill_level = 5'(fill);
            r.is_empty   = fill == 0;
            r.is_full    = fill >= lim;
            r.free_slots = (lim > fill) ? 5'(lim - fill) : 5'd0;
            r.in_order   = 1'b1;
            for (i = 1; i < fill; i++)
                if (slots[i-1] > slots[i])
                    r.in_order = 1'b0;
            pending_outcomes.push_back(r);
        endfunction

        function void compare_field(string name, logic signed [63:0] want,
                                    logic signed [63:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic ok, logic signed [31:0] value_out,
                                   logic [3:0] index_out, logic [4:0] fill_level,
                                   logic is_empty, logic is_full,
                                   logic [4:0] free_slots, logic in_order);
            list_outcome_t want;
            if (pending_outcomes.size() == 0)
            begin
                $error("result word with no command outstanding");
                errors++;
                return;
            end
            want = pending_outcomes.pop_front();
            results++;
            if (is_full === 1'b1)
                full_results++;
            if (in_order === 1'b0)
                unordered_results++;
            compare_field("ok", want.ok, ok);
            compare_field("value_out", want.value_out, value_out);
            compare_field("index_out", want.index_out, index_out);
            compare_field("fill_level", want.fill_level, fill_level);
            compare_field("is_empty", want.is_empty, is_empty);
            compare_field("is_full", want.is_full, is_full);
            compare_field("free_slots", want.free_slots, free_slots);
            compare_field("in_order", want.in_order, in_order);
        endfunction
    endclass

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic               in_stall;
    logic [3:0]         command    = CMD_STATUS;
    logic signed [31:0] value      = '0;
    logic [4:0]         position   = '0;
    logic               out_valid;
    logic               out_stall  = 1'b0;
    logic               ok;
    logic signed [31:0] value_out;
    logic [3:0]         index_out;
    logic [4:0]         fill_level;
    logic               is_empty;
    logic               is_full;
    logic [4:0]         free_slots;
    logic               in_order;
    logic               cfg_valid  = 1'b0;
    logic               cfg_ready;
    logic [4:0]         cfg_data   = '0;

    list_scoreboard sb = new();

    bit tx_quiet   = 1'b0;
    bit rx_busy    = 1'b0;
    int stall_left = 0;

    positional_sorted_list_engine_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .value      (value),
        .position   (position),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .ok         (ok),
        .value_out  (value_out),
        .index_out  (index_out),
        .fill_level (fill_level),
        .is_empty   (is_empty),
        .is_full    (is_full),
        .free_slots (free_slots),
        .in_order   (in_order),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_limit(cfg_data);
            if (in_valid && !in_stall)
                sb.take_command(command, value, position);
            if (out_valid && !out_stall)
                sb.check_result(ok, value_out, index_out, fill_level, is_empty, is_full,
                                free_slots, in_order);
        end
    end

    // receiver back-pressure: mostly short stalls, occasionally long ones
    always @(posedge clk)
    begin
        int r;
        r = $urandom_range(0, 99);
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (!rx_busy || r < 70)
            out_stall <= 1'b0;
        else if (r < 96)
        begin
            stall_left <= $urandom_range(0, 2);
            out_stall  <= 1'b1;
        end
        else
        begin
            stall_left <= $urandom_range(10, 40);
            out_stall  <= 1'b1;
        end
    end

    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_quiet || r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return 0;
            3:       return -1;
            4:       return 1;
            5:       return 7;
            6:       return -5;
            7:       return 100;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [3:0] pick_command(bit keep_sorted);
        int r;
        r = $urandom_range(0, 99);
        if (keep_sorted)
        begin
            if (r < 35) return CMD_SORTED;
            if (r < 55) return CMD_FIND;
            if (r < 70) return CMD_READ;
            if (r < 80) return CMD_REMOVE;
            if (r < 88) return CMD_DROP;
            if (r < 97) return CMD_STATUS;
            return CMD_CLEAR;
        end
        if (r < 18) return CMD_APPEND;
        if (r < 32) return CMD_SORTED;
        if (r < 44) return CMD_INSERT;
        if (r < 54) return CMD_REMOVE;
        if (r < 61) return CMD_DROP;
        if (r < 71) return CMD_FIND;
        if (r < 81) return CMD_READ;
        if (r < 86) return CMD_REVERSE;
        if (r < 90) return CMD_STATUS;
        if (r < 92) return CMD_CLEAR;
        return 4'($urandom_range(FIRST_UNUSED_CMD, LAST_UNUSED_CMD));
    endfunction

    task automatic send_word(input logic [3:0] c, input logic signed [31:0] v,
                             input logic [4:0] p);
        int gap;
        in_valid <= 1'b1;
        command  <= c;
        value    <= v;
        position <= p;
        do @(posedge clk); while (in_stall);
        gap = sender_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_results_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    task automatic write_capacity(input logic [4:0] lim);
        wait_results_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= lim;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [4:0] phase_limit [PHASES];
        int         ph;
        int         n;
        int         guard;
        logic [4:0] p;

        phase_limit = '{5'd1, 5'd0, 5'd31, 5'd16, 5'd5, 5'd15, 5'd17, 5'd9, 5'd16};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list corner cases, extremes, every opcode except clear, unused opcodes
        send_word(CMD_STATUS, 0, 0);
        send_word(CMD_DROP, 0, 0);
        send_word(CMD_REMOVE, 0, 0);
        send_word(CMD_READ, 0, 0);
        send_word(CMD_FIND, 0, 0);
        send_word(CMD_REVERSE, 0, 0);
        send_word(CMD_INSERT, 3, 1);
        send_word(CMD_APPEND, 32'sh7FFF_FFFF, 0);
        send_word(CMD_APPEND, 32'sh8000_0000, 0);
        send_word(CMD_SORTED, 5, 0);
        send_word(CMD_INSERT, -1, 0);
        send_word(CMD_INSERT, 5, 4);
        send_word(CMD_FIND, 32'sh8000_0000, 0);
        send_word(CMD_READ, 0, 4);
        send_word(CMD_REVERSE, 0, 0);
        send_word(CMD_SORTED, 5, 0);
        send_word(CMD_REMOVE, 0, 0);
        send_word(CMD_READ, 0, 5'd31);
        send_word(FIRST_UNUSED_CMD, 0, 0);
        send_word(LAST_UNUSED_CMD, -1, 5'd31);

        // limit dropped below the current fill
        write_capacity(5'd3);
        send_word(CMD_STATUS, 0, 0);
        send_word(CMD_APPEND, 9, 0);
        send_word(CMD_INSERT, 9, 0);
        send_word(CMD_SORTED, 9, 0);
        send_word(CMD_DROP, 0, 0);
        send_word(CMD_CLEAR, 0, 0);

        for (ph = 0; ph < PHASES; ph++)
        begin
            write_capacity(phase_limit[ph]);
            tx_quiet = (ph == 2 || ph == 5);
            rx_busy  = (ph % 3 != 0);
            for (n = 0; n < PHASE_WORDS; n++)
            begin
                if ($urandom_range(0, 9) != 0)
                    p = 5'($urandom_range(0, sb.fill + 1));
                else
                    p = 5'($urandom_range(0, 31));
                send_word(pick_command(ph == 3 || ph == 7), pick_value(), p);
                if ($urandom_range(0, 149) == 0)
                    wait_results_drained();
            end
        end

        in_valid <= 1'b0;
        for (guard = 0; sb.pending() != 0 && guard < 20000; guard++)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.pending() != 0)
        begin
            $error("%0d expected result words never arrived", sb.pending());
            sb.errors++;
        end

        $display("%0d commands under %0d capacity settings, %0d result words checked",
                 sb.commands, sb.limit_writes + 1, sb.results);
        $display("%0d results with the list full, %0d with the list out of order",
                 sb.full_results, sb.unordered_results);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
